// ===== rtl/core/lkt_pkg.sv =====
// shared types, character codes and token codes for the logic keyword tokenizer
package lkt_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = PTR_W + 1;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_N    = 13'b0000000000010,
        ST_NO   = 13'b0000000000100,
        ST_A    = 13'b0000000001000,
        ST_AN   = 13'b0000000010000,
        ST_O    = 13'b0000000100000,
        ST_X    = 13'b0000001000000,
        ST_XO   = 13'b0000010000000,
        ST_I    = 13'b0000100000000,
        ST_IF   = 13'b0001000000000,
        ST_T    = 13'b0010000000000,
        ST_TH   = 13'b0100000000000,
        ST_THE  = 13'b1000000000000
    } kw_state_t;

    typedef enum logic [3:0] {
        TK_OPERAND = 4'd0,
        TK_NOT     = 4'd1,
        TK_AND     = 4'd2,
        TK_OR      = 4'd3,
        TK_XOR     = 4'd4,
        TK_IF      = 4'd5,
        TK_THEN    = 4'd6,
        TK_IFF     = 4'd7,
        TK_OPEN    = 4'd8,
        TK_CLOSE   = 4'd9,
        TK_ERROR   = 4'd10
    } token_kind_t;

    typedef enum logic [1:0] {
        LT_P = 2'd0,
        LT_Q = 2'd1,
        LT_R = 2'd2,
        LT_S = 2'd3
    } letter_t;

    typedef struct packed {
        token_kind_t kind;
        letter_t     letter;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
        kw_state_t  next_state;
    } dec_t;

endpackage

// ===== rtl/core/lkt_if.sv =====
// valid/ready channel interfaces for character and token beats
interface lkt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

interface lkt_token_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [1:0] operand_letter;
    logic       last_of_run;

    modport source (output valid, output token_kind, output operand_letter,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input operand_letter,
                  input last_of_run, output ready);
endinterface

// ===== rtl/core/lkt_decode.sv =====
// keyword recognizer next-state and token decode for one character
module lkt_decode
(
    input  lkt_pkg::kw_state_t state,
    input  logic [7:0]         character,
    output lkt_pkg::dec_t      dec
);

    typedef struct packed {
        logic               hit;
        lkt_pkg::token_t    tok;
        lkt_pkg::kw_state_t st;
    } start_t;

    function automatic start_t start_char(input logic [7:0] c);
        start_t s;
        s.hit        = 1'b0;
        s.tok.kind   = lkt_pkg::TK_OPERAND;
        s.tok.letter = lkt_pkg::LT_P;
        s.tok.last   = 1'b1;
        s.st         = lkt_pkg::ST_IDLE;
        case (c)
            lkt_pkg::CH_P:     s.hit = 1'b1;
            lkt_pkg::CH_Q:
            begin
                s.hit        = 1'b1;
                s.tok.letter = lkt_pkg::LT_Q;
            end
            lkt_pkg::CH_R:
            begin
                s.hit        = 1'b1;
                s.tok.letter = lkt_pkg::LT_R;
            end
            lkt_pkg::CH_S:
            begin
                s.hit        = 1'b1;
                s.tok.letter = lkt_pkg::LT_S;
            end
            lkt_pkg::CH_OPEN:
            begin
                s.hit      = 1'b1;
                s.tok.kind = lkt_pkg::TK_OPEN;
            end
            lkt_pkg::CH_CLOSE:
            begin
                s.hit      = 1'b1;
                s.tok.kind = lkt_pkg::TK_CLOSE;
            end
            lkt_pkg::CH_N:     s.st = lkt_pkg::ST_N;
            lkt_pkg::CH_A:     s.st = lkt_pkg::ST_A;
            lkt_pkg::CH_O:     s.st = lkt_pkg::ST_O;
            lkt_pkg::CH_X:     s.st = lkt_pkg::ST_X;
            lkt_pkg::CH_I:     s.st = lkt_pkg::ST_I;
            lkt_pkg::CH_T:     s.st = lkt_pkg::ST_T;
            default:           s.hit = 1'b0;
        endcase
        return s;
    endfunction

    logic [7:0]           want;
    lkt_pkg::kw_state_t   step_state;
    lkt_pkg::token_kind_t done_kind;
    logic                 completes;
    logic                 idle;
    start_t               restart;
    lkt_pkg::token_t      plain_tok;

    always_comb
    begin
        want       = lkt_pkg::CH_NUL;
        step_state = lkt_pkg::ST_IDLE;
        done_kind  = lkt_pkg::TK_ERROR;
        completes  = 1'b0;
        idle       = 1'b0;
        case (state)
            lkt_pkg::ST_N:
            begin
                want       = lkt_pkg::CH_O;
                step_state = lkt_pkg::ST_NO;
            end
            lkt_pkg::ST_NO:
            begin
                want      = lkt_pkg::CH_T;
                done_kind = lkt_pkg::TK_NOT;
                completes = 1'b1;
            end
            lkt_pkg::ST_A:
            begin
                want       = lkt_pkg::CH_N;
                step_state = lkt_pkg::ST_AN;
            end
            lkt_pkg::ST_AN:
            begin
                want      = lkt_pkg::CH_D;
                done_kind = lkt_pkg::TK_AND;
                completes = 1'b1;
            end
            lkt_pkg::ST_O:
            begin
                want      = lkt_pkg::CH_R;
                done_kind = lkt_pkg::TK_OR;
                completes = 1'b1;
            end
            lkt_pkg::ST_X:
            begin
                want       = lkt_pkg::CH_O;
                step_state = lkt_pkg::ST_XO;
            end
            lkt_pkg::ST_XO:
            begin
                want      = lkt_pkg::CH_R;
                done_kind = lkt_pkg::TK_XOR;
                completes = 1'b1;
            end
            lkt_pkg::ST_I:
            begin
                want       = lkt_pkg::CH_F;
                step_state = lkt_pkg::ST_IF;
            end
            lkt_pkg::ST_IF:
            begin
                want      = lkt_pkg::CH_F;
                done_kind = lkt_pkg::TK_IFF;
                completes = 1'b1;
            end
            lkt_pkg::ST_T:
            begin
                want       = lkt_pkg::CH_H;
                step_state = lkt_pkg::ST_TH;
            end
            lkt_pkg::ST_TH:
            begin
                want       = lkt_pkg::CH_E;
                step_state = lkt_pkg::ST_THE;
            end
            lkt_pkg::ST_THE:
            begin
                want      = lkt_pkg::CH_N;
                done_kind = lkt_pkg::TK_THEN;
                completes = 1'b1;
            end
            default:           idle = 1'b1;
        endcase
    end

    assign restart = start_char(character);

    always_comb
    begin
        plain_tok.kind   = lkt_pkg::TK_ERROR;
        plain_tok.letter = lkt_pkg::LT_P;
        plain_tok.last   = 1'b1;

        dec.count      = 2'd0;
        dec.tok0       = plain_tok;
        dec.tok1       = restart.tok;
        dec.next_state = lkt_pkg::ST_IDLE;

        if (idle)
        begin
            dec.count      = {1'b0, restart.hit};
            dec.tok0       = restart.tok;
            dec.next_state = restart.st;
        end
        else if (character == want)
        begin
            if (completes)
            begin
                dec.count     = 2'd1;
                dec.tok0.kind = done_kind;
            end
            else
            begin
                dec.next_state = step_state;
            end
        end
        else if (state == lkt_pkg::ST_IF && character == lkt_pkg::CH_SPACE)
        begin
            dec.count     = 2'd1;
            dec.tok0.kind = lkt_pkg::TK_IF;
        end
        else
        begin
            // error token, then the same character again from idle
            dec.count      = restart.hit ? 2'd2 : 2'd1;
            dec.tok0.last  = ~restart.hit;
            dec.next_state = restart.st;
        end
    end

endmodule

// ===== rtl/core/lkt_tok_fifo.sv =====
// small token queue taking up to two tokens per cycle and giving one
module lkt_tok_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lkt_pkg::dec_t         dec,
    output logic                  room2,
    lkt_token_if.source           tokens
);

    lkt_pkg::token_t mem_reg [lkt_pkg::FIFO_DEPTH];

    logic [lkt_pkg::PTR_W-1:0] wr_ptr_reg;
    logic [lkt_pkg::PTR_W-1:0] wr_ptr_next;
    logic [lkt_pkg::PTR_W-1:0] wr_ptr_b;
    logic [lkt_pkg::PTR_W-1:0] rd_ptr_reg;
    logic [lkt_pkg::PTR_W-1:0] rd_ptr_next;
    logic [lkt_pkg::CNT_W-1:0] count_reg;
    logic [lkt_pkg::CNT_W-1:0] count_next;
    logic [1:0]                push_n;
    logic                      pop;
    lkt_pkg::token_t           head;

    assign push_n  = push ? dec.count : 2'd0;
    assign pop     = tokens.valid & tokens.ready;
    assign wr_ptr_b = wr_ptr_reg + lkt_pkg::PTR_W'(1);

    assign wr_ptr_next = wr_ptr_reg + lkt_pkg::PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + lkt_pkg::PTR_W'(pop);
    assign count_next  = count_reg + lkt_pkg::CNT_W'(push_n) - lkt_pkg::CNT_W'(pop);

    assign room2 = count_reg <= lkt_pkg::CNT_W'(lkt_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= dec.tok0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_b] <= dec.tok1;
        end
    end

    assign head                  = mem_reg[rd_ptr_reg];
    assign tokens.valid          = count_reg != '0;
    assign tokens.token_kind     = head.kind;
    assign tokens.operand_letter = head.letter;
    assign tokens.last_of_run    = head.last;

endmodule

// ===== rtl/core/logic_keyword_tokenizer.sv =====
// top level: streaming tokenizer for propositional-logic text
// an accepted character beat is registered, then decoded, and its tokens go to the queue
// throughput: one character per cycle while the queue has room for two tokens;
//   the queue drains one token per cycle while tokens.ready is high
// reset: rst_n asynchronous active low, clears the recognizer to idle and empties the queue
module logic_keyword_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    lkt_char_if.sink    chars,
    lkt_token_if.source tokens
);

    logic               in_valid_reg;
    logic [7:0]         char_reg;
    lkt_pkg::kw_state_t state_reg;
    lkt_pkg::dec_t      dec;
    logic               room2;
    logic               consume;

    assign consume     = in_valid_reg & room2;
    assign chars.ready = ~in_valid_reg | consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= lkt_pkg::ST_IDLE;
        end
        else
        begin
            if (chars.ready)
            begin
                in_valid_reg <= chars.valid;
            end
            if (consume)
            begin
                state_reg <= dec.next_state;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.character;
        end
    end

    lkt_decode u_decode
    (
        .state     (state_reg),
        .character (char_reg),
        .dec       (dec)
    );

    lkt_tok_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (consume),
        .dec    (dec),
        .room2  (room2),
        .tokens (tokens)
    );

endmodule

// ===== sim/logic_keyword_tokenizer_test.sv =====
// self-checking testbench for the logic keyword tokenizer with a built-in token predictor
`timescale 1ns / 100ps

module logic_keyword_tokenizer_test;

    import lkt_pkg::*;

    localparam int STUCK_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 10;
    localparam int PHASE_CHARS  = 325;

    typedef struct {
        logic [7:0] ch;
        int         n;
        token_t     t0;
        token_t     t1;
    } dir_row_t;

    logic clk;
    logic rst_n;

    lkt_char_if  chars();
    lkt_token_if tokens();

    logic_keyword_tokenizer DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .tokens (tokens)
    );

    kw_state_t kw_state;
    token_t    expected_tokens[$];
    int        send_idle_pct;
    int        stall_pct;
    int        chars_sent;
    int        double_runs;
    int        tokens_checked;
    int        error_tokens;
    int        mismatches;
    int        stuck_cycles;
    string     keywords[7] = '{"not", "and", "or", "xor", "if", "iff", "then"};
    dir_row_t  directed_rows[29];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic token_t tok(input token_kind_t k, input letter_t l, input logic last);
        token_t t;
        t.kind   = k;
        t.letter = l;
        t.last   = last;
        return t;
    endfunction

    // n below zero: the predictor decides the tokens
    function automatic dir_row_t row(input logic [7:0] c, input int n = -1,
                                     input token_t t0 = '0, input token_t t1 = '0);
        dir_row_t r;
        r.ch = c;
        r.n  = n;
        r.t0 = t0;
        r.t1 = t1;
        return r;
    endfunction

    function automatic int from_idle(input logic [7:0] c, output token_t t);
        int found;
        found = 1;
        t = tok(TK_OPERAND, LT_P, 1'b0);
        kw_state = ST_IDLE;
        case (c)
            CH_P:     t.letter = LT_P;
            CH_Q:     t.letter = LT_Q;
            CH_R:     t.letter = LT_R;
            CH_S:     t.letter = LT_S;
            CH_OPEN:  t.kind = TK_OPEN;
            CH_CLOSE: t.kind = TK_CLOSE;
            CH_N:
            begin
                kw_state = ST_N;
                found = 0;
            end
            CH_A:
            begin
                kw_state = ST_A;
                found = 0;
            end
            CH_O:
            begin
                kw_state = ST_O;
                found = 0;
            end
            CH_X:
            begin
                kw_state = ST_X;
                found = 0;
            end
            CH_I:
            begin
                kw_state = ST_I;
                found = 0;
            end
            CH_T:
            begin
                kw_state = ST_T;
                found = 0;
            end
            default: found = 0;
        endcase
        return found;
    endfunction

    function automatic int predict_tokens(input logic [7:0] c, output token_t t0,
                                          output token_t t1);
        logic [7:0]  want;
        kw_state_t   nxt;
        token_kind_t done;
        logic        completes;
        int          n;
        want      = CH_NUL;
        nxt       = ST_IDLE;
        done      = TK_ERROR;
        completes = 1'b0;
        n         = 0;
        t0        = tok(TK_OPERAND, LT_P, 1'b0);
        t1        = t0;
        case (kw_state)
            ST_N:
            begin
                want = CH_O;
                nxt  = ST_NO;
            end
            ST_NO:
            begin
                want = CH_T;
                done = TK_NOT;
                completes = 1'b1;
            end
            ST_A:
            begin
                want = CH_N;
                nxt  = ST_AN;
            end
            ST_AN:
            begin
                want = CH_D;
                done = TK_AND;
                completes = 1'b1;
            end
            ST_O:
            begin
                want = CH_R;
                done = TK_OR;
                completes = 1'b1;
            end
            ST_X:
            begin
                want = CH_O;
                nxt  = ST_XO;
            end
            ST_XO:
            begin
                want = CH_R;
                done = TK_XOR;
                completes = 1'b1;
            end
            ST_I:
            begin
                want = CH_F;
                nxt  = ST_IF;
            end
            ST_IF:
            begin
                want = CH_F;
                done = TK_IFF;
                completes = 1'b1;
            end
            ST_T:
            begin
                want = CH_H;
                nxt  = ST_TH;
            end
            ST_TH:
            begin
                want = CH_E;
                nxt  = ST_THE;
            end
            ST_THE:
            begin
                want = CH_N;
                done = TK_THEN;
                completes = 1'b1;
            end
            default: kw_state = ST_IDLE;
        endcase
        if (kw_state == ST_IDLE)
            n = from_idle(c, t0);
        else if (c == want)
        begin
            if (completes)
            begin
                t0.kind  = done;
                n        = 1;
                kw_state = ST_IDLE;
            end
            else
                kw_state = nxt;
        end
        else if (kw_state == ST_IF && c == CH_SPACE)
        begin
            // "if" closed by a space; the space itself is skipped
            t0.kind  = TK_IF;
            n        = 1;
            kw_state = ST_IDLE;
        end
        else
        begin
            // broken keyword, then the same byte again from idle
            t0.kind = TK_ERROR;
            n = 1 + from_idle(c, t1);
        end
        if (n == 1)
            t0.last = 1'b1;
        if (n == 2)
            t1.last = 1'b1;
        return n;
    endfunction

    task automatic send_char(input dir_row_t r);
        token_t t0;
        token_t t1;
        int     n;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid     <= 1'b1;
        chars.character <= r.ch;
        do
            @(posedge clk);
        while (!chars.ready);
        n = predict_tokens(r.ch, t0, t1);
        if (r.n >= 0)
        begin
            n  = r.n;
            t0 = r.t0;
            t1 = r.t1;
        end
        if (n > 0)
            expected_tokens.push_back(t0);
        if (n > 1)
        begin
            expected_tokens.push_back(t1);
            double_runs++;
        end
        chars_sent++;
    endtask

    // one word of text: mostly well-formed tokens, some broken keywords and noise
    task automatic send_phrase();
        logic [7:0] text[$];
        string      word;
        int         pick;
        int         cut;
        int         sep;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            text.push_back(CH_P + 8'($urandom_range(0, 3)));
        else if (pick < 45)
            text.push_back($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
        else if (pick < 90)
        begin
            word = keywords[$urandom_range(0, 6)];
            cut  = (pick < 80) ? word.len() : $urandom_range(1, word.len() - 1);
            for (int i = 0; i < cut; i++)
                text.push_back(word[i]);
            if (pick >= 80)
                text.push_back(8'($urandom_range(0, 255)));
        end
        else
            text.push_back(8'($urandom_range(0, 255)));
        sep = $urandom_range(0, 99);
        if (sep < 70)
            text.push_back(CH_SPACE);
        else if (sep < 85)
            text.push_back(CH_NUL);
        else if (sep < 92)
            text.push_back(8'($urandom_range(0, 255)));
        foreach (text[i])
            send_char(row(text[i]));
    endtask

    always @(posedge clk)
    begin : token_check
        token_t want;
        if (rst_n && tokens.valid && tokens.ready)
        begin
            tokens_checked++;
            if (tokens.token_kind == TK_ERROR)
                error_tokens++;
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected token, expected none, got kind %0d letter %0d last %0d",
                         $time, tokens.token_kind, tokens.operand_letter, tokens.last_of_run);
                mismatches++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (tokens.token_kind != want.kind)
                begin
                    $display("%0t: token_kind expected %0d got %0d", $time, want.kind,
                             tokens.token_kind);
                    mismatches++;
                end
                if (tokens.operand_letter != want.letter)
                begin
                    $display("%0t: operand_letter expected %0d got %0d", $time, want.letter,
                             tokens.operand_letter);
                    mismatches++;
                end
                if (tokens.last_of_run != want.last)
                begin
                    $display("%0t: last_of_run expected %0d got %0d", $time, want.last,
                             tokens.last_of_run);
                    mismatches++;
                end
            end
        end
        tokens.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (chars.valid && chars.ready) || (tokens.valid && tokens.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int pacing[4][2];
        int target;
        pacing          = '{'{0, 0}, '{60, 0}, '{0, 60}, '{37, 37}};
        clk             = 1'b0;
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.character = CH_NUL;
        tokens.ready    = 1'b0;
        kw_state        = ST_IDLE;
        send_idle_pct   = 0;
        stall_pct       = 0;
        chars_sent      = 0;
        double_runs     = 0;
        tokens_checked  = 0;
        error_tokens    = 0;
        mismatches      = 0;
        stuck_cycles    = 0;
        directed_rows = '{
            row(CH_NUL, 0),
            row(CH_CLOSE, 1, tok(TK_CLOSE, LT_P, 1'b1)),
            row(CH_N), row(CH_O), row(CH_T),
            row(CH_A), row(CH_N), row(CH_D),
            row(CH_O), row(CH_R),
            row(CH_X), row(CH_O), row(CH_R),
            row(CH_I), row(CH_F), row(CH_SPACE),
            row(CH_I), row(CH_F), row(CH_F),
            row(CH_T), row(CH_H), row(CH_E), row(CH_N),
            // broken keyword that also yields an operand
            row(CH_X), row(CH_S, 2, tok(TK_ERROR, LT_P, 1'b0), tok(TK_OPERAND, LT_S, 1'b1)),
            // broken keyword on the top byte value, which idle then skips
            row(CH_A), row(8'hff, 1, tok(TK_ERROR, LT_P, 1'b1)),
            // end of string inside a keyword
            row(CH_I), row(CH_NUL, 1, tok(TK_ERROR, LT_P, 1'b1))
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = pacing[phase][0];
            stall_pct     = pacing[phase][1];
            if (phase == 0)
                foreach (directed_rows[i])
                    send_char(directed_rows[i]);
            target = chars_sent + PHASE_CHARS;
            while (chars_sent < target)
                send_phrase();
        end
        chars.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("tb: %0d characters sent across four pacing phases, %0d tokens checked",
                 chars_sent, tokens_checked);
        $display("tb: %0d error tokens seen, %0d characters gave two tokens",
                 error_tokens, double_runs);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lkt_pkg.sv
rtl/core/lkt_if.sv
rtl/core/lkt_decode.sv
rtl/core/lkt_tok_fifo.sv
rtl/core/logic_keyword_tokenizer.sv
sim/logic_keyword_tokenizer_test.sv
